### rtl/least_busy_weighted_picker_defines.svh
// ----------------------------------------------------------------------------
// Least-busy weighted picker - assertion macros
// Shared property wrappers for the checker; all sample on the rising edge
// and are switched off while reset is low.
// ----------------------------------------------------------------------------
`ifndef LEAST_BUSY_WEIGHTED_PICKER_DEFINES_SVH
`define LEAST_BUSY_WEIGHTED_PICKER_DEFINES_SVH

// same-cycle implication
`define LBWP_ASSERT_NOW(name, clk, rst_n, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBWP_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lbwp_pkg.sv
// ----------------------------------------------------------------------------
// Least-busy weighted picker - package
// Field widths, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lbwp_pkg;

	// item field widths
	localparam int IDX_W    = 3;
	localparam int WEIGHT_W = 7;
	localparam int GROUP_W  = 4;
	localparam int LOAD_W   = 16;
	localparam int CREDIT_W = 16;

	// class key is {group, standby}, standby after active within a group
	localparam int KEY_W = GROUP_W + 1;

	// shared adder width, wide enough for credit plus or minus any total
	localparam int ADD_W = CREDIT_W + 2;

	// action codes
	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_PICK  = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASS,
		ST_SCAN,
		ST_COMMIT
	} lbwp_state_t;

endpackage

### rtl/least_busy_weighted_picker.sv
// ----------------------------------------------------------------------------
// Least-busy weighted picker
// Server table with weights, priority groups and credits; a pick item
// chooses the least loaded usable server of the first non-empty class.
// ----------------------------------------------------------------------------
// channel  | handshake          | fields
// ---------+--------------------+---------------------------------------------
// item in  | start & !busy      | action, server_index, weight, priority_set,
//          |                    | is_standby, is_usable, outstanding
// result   | done (one cycle)   | found, picked_index
//
// A write item completes at its accepting edge; busy stays low and no result
// follows. A pick item holds busy through a class pass over the table (D =
// table depth, 8 by default) to find the first class with a usable member, a
// scan pass to raise credits and compare loads, and a commit that charges the
// winner. The sequencer walks the table one entry a cycle through a single
// shared adder. With nothing usable the pick ends after the class pass. done
// pulses in the first cycle with busy low again.
// Reset clears the table and the sequencer; the receiver cannot stall.
// ----------------------------------------------------------------------------
module least_busy_weighted_picker #(
	parameter int NUM_SERVERS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [lbwp_pkg::IDX_W-1:0]    server_index,
	input  logic [lbwp_pkg::WEIGHT_W-1:0] weight,
	input  logic [lbwp_pkg::GROUP_W-1:0]  priority_set,
	input  logic                          is_standby,
	input  logic                          is_usable,
	input  logic [lbwp_pkg::LOAD_W-1:0]   outstanding,
	output logic                          done,
	output logic                          found,
	output logic [lbwp_pkg::IDX_W-1:0]    picked_index
);
	import lbwp_pkg::*;

	// the index field reaches eight servers, entries above stay unusable
	localparam int DEPTH = (NUM_SERVERS < (1 << IDX_W)) ? NUM_SERVERS : (1 << IDX_W);
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = WEIGHT_W + IW;

	// server table
	logic [WEIGHT_W-1:0]        weight_q   [DEPTH];
	logic [GROUP_W-1:0]         group_q    [DEPTH];
	logic                       standby_q  [DEPTH];
	logic                       usable_q   [DEPTH];
	logic [LOAD_W-1:0]          load_q     [DEPTH];
	logic signed [CREDIT_W-1:0] credit_q   [DEPTH];

	// sequencer and search registers
	lbwp_state_t                state_q, state_d;
	logic [IW-1:0]              cnt_q;
	logic                       any_q;
	logic [KEY_W-1:0]           key_q;
	logic                       have_best_q;
	logic [IW-1:0]              best_idx_q;
	logic [LOAD_W-1:0]          best_load_q;
	logic signed [CREDIT_W-1:0] best_credit_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       done_q, found_q;
	logic [IDX_W-1:0]           picked_q;

	// datapath signals
	logic                       accept, wr_en, pick_go, cnt_last;
	logic [IW-1:0]              rd_idx;
	logic [KEY_W-1:0]           cur_key;
	logic                       cur_usable, key_take, in_class, best_take;
	logic                       any_d;
	logic [KEY_W-1:0]           key_d;
	logic signed [ADD_W-1:0]    add_a, add_b, add_sum;
	logic signed [CREDIT_W-1:0] sat_out;

	assign accept   = start && !busy;
	assign wr_en    = accept && (action == ACTION_WRITE) && (32'(server_index) < NUM_SERVERS);
	assign pick_go  = accept && (action == ACTION_PICK);
	assign cnt_last = (cnt_q == IW'(DEPTH - 1));
	assign busy     = (state_q != ST_IDLE);

	// credit read index: winner during commit, scan entry otherwise
	assign rd_idx     = (state_q == ST_COMMIT) ? best_idx_q : cnt_q;
	assign cur_key    = {group_q[cnt_q], standby_q[cnt_q]};
	assign cur_usable = usable_q[cnt_q];

	// class search: lowest key among usable servers
	assign key_take = cur_usable && (!any_q || (cur_key < key_q));
	assign any_d    = any_q || cur_usable;
	assign key_d    = key_take ? cur_key : key_q;

	// shared saturating adder: credit plus weight, or credit minus class total
	always_comb begin
		add_a = ADD_W'(credit_q[rd_idx]);
		if (state_q == ST_COMMIT) begin
			add_b = -$signed({{(ADD_W - SUM_W){1'b0}}, sum_q});
		end else begin
			add_b = $signed({{(ADD_W - WEIGHT_W){1'b0}}, weight_q[cnt_q]});
		end
		add_sum = add_a + add_b;
		if (add_sum[ADD_W-1:CREDIT_W-1] == '0 || add_sum[ADD_W-1:CREDIT_W-1] == '1) begin
			sat_out = add_sum[CREDIT_W-1:0];
		end else if (add_sum[ADD_W-1]) begin
			sat_out = {1'b1, {(CREDIT_W - 1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(CREDIT_W - 1){1'b1}}};
		end
	end

	// winner compare: fewer outstanding, then larger raised credit, then lower index
	assign in_class  = cur_usable && (cur_key == key_q);
	assign best_take = in_class && (!have_best_q || (load_q[cnt_q] < best_load_q) ||
		((load_q[cnt_q] == best_load_q) && (sat_out > best_credit_q)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pick_go) state_d = ST_CLASS;
			end
			ST_CLASS: begin
				if (cnt_last) state_d = any_d ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (cnt_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counter and search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			any_q       <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q       <= '0;
					any_q       <= 1'b0;
					have_best_q <= 1'b0;
				end
				ST_CLASS: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					any_q <= any_d;
				end
				ST_SCAN: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (best_take) have_best_q <= 1'b1;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
		end
		if (state_q == ST_CLASS) begin
			key_q <= key_d;
		end
		if (state_q == ST_SCAN && in_class) begin
			sum_q <= sum_q + SUM_W'(weight_q[cnt_q]);
		end
		if (state_q == ST_SCAN && best_take) begin
			best_idx_q    <= cnt_q;
			best_load_q   <= load_q[cnt_q];
			best_credit_q <= sat_out;
		end
	end

	// server table: record writes and credit updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				weight_q[i]  <= '0;
				group_q[i]   <= '0;
				standby_q[i] <= 1'b0;
				usable_q[i]  <= 1'b0;
				load_q[i]    <= '0;
				credit_q[i]  <= '0;
			end
		end else begin
			if (wr_en) begin
				weight_q[server_index[IW-1:0]]  <= weight;
				group_q[server_index[IW-1:0]]   <= priority_set;
				standby_q[server_index[IW-1:0]] <= is_standby;
				usable_q[server_index[IW-1:0]]  <= is_usable;
				load_q[server_index[IW-1:0]]    <= outstanding;
			end
			if ((state_q == ST_SCAN && in_class) || state_q == ST_COMMIT) begin
				credit_q[rd_idx] <= sat_out;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_COMMIT) || (state_q == ST_CLASS && cnt_last && !any_d);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			found_q  <= 1'b1;
			picked_q <= IDX_W'(best_idx_q);
		end else if (state_q == ST_CLASS && cnt_last && !any_d) begin
			found_q  <= 1'b0;
			picked_q <= '0;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign picked_index = picked_q;

endmodule

### rtl/lbwp_checker.sv
// ----------------------------------------------------------------------------
// Least-busy weighted picker - port checker
// Watches the top level's ports for sequencing slips between items and
// results.
// ----------------------------------------------------------------------------
`include "least_busy_weighted_picker_defines.svh"

module lbwp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       action,
	input logic                       done,
	input logic                       found,
	input logic [lbwp_pkg::IDX_W-1:0] picked_index
);
	import lbwp_pkg::*;

	// a pick item makes the block busy
	`LBWP_ASSERT_NEXT(a_pick_busy, clk, arst_n, start && !busy && (action == ACTION_PICK), busy, "pick item did not start work")

	// a write item gives no result and no busy time
	`LBWP_ASSERT_NEXT(a_write_quiet, clk, arst_n, start && !busy && (action == ACTION_WRITE), !busy && !done, "write item produced activity")

	// a result only follows the end of a pick
	`LBWP_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, !busy && $past(busy), "result without pick")

	// an empty result names server zero
	`LBWP_ASSERT_NOW(a_empty_index, clk, arst_n, done && !found, picked_index == '0, "empty result with nonzero index")

endmodule

bind least_busy_weighted_picker lbwp_checker u_lbwp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.action       (action),
	.done         (done),
	.found        (found),
	.picked_index (picked_index)
);
